@@ rtl/cwai_pkg.sv @@
// ----------------------------------------------------------------------------
// cwai_pkg
// Shared types and constants of the column wave activity integrator.
// ----------------------------------------------------------------------------
package cwai_pkg;

  localparam int DATA_W  = 32;
  localparam int RIU_W   = 7;
  localparam int DENOM   = 15625;        // 5^6, divisor of the contour term
  localparam int REM_W   = 14;           // remainder below DENOM
  localparam int MAG_W   = 66;           // magnitude of the scaled excess
  localparam int DIV_CHUNK = 18;         // dividend digit, {rem, digit} fits 32 bits
  localparam int DIV_STEPS = 4;
  localparam int DQ_W    = DIV_CHUNK * DIV_STEPS;
  localparam int RECIP_SHIFT = 45;
  localparam logic [31:0] RECIP = 32'd2251799814;  // ceil(2^45 / DENOM)
  localparam int CNT_W   = 7;
  localparam int DMAG_W  = 54;           // magnitude of one excess
  localparam int DHALF_W = DMAG_W / 2;
  localparam int WSUM_W  = DATA_W + 1;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = 96;
  localparam int FIN_W   = 128;
  localparam int FIN_SHIFT = 54;
  localparam int LIMB_W  = 2;
  localparam logic [LIMB_W-1:0] LAST_LIMB = 2'd2;

  localparam logic [RIU_W-1:0]  RIU_RESET = 7'd64;
  localparam logic [DATA_W-1:0] SDM_RESET = 32'd66;

  typedef enum logic {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_STABLE_MIN  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_PAIR_RD,
    ST_PAIR_MUL,
    ST_PAIR_SUB,
    ST_DIV_MUL,
    ST_DIV,
    ST_TERM_LO,
    ST_TERM_HI,
    ST_TERM_ADD,
    ST_FIN_MUL,
    ST_FIN_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic              acc_clr;
    logic              mul_ps;
    logic              form_x;
    logic              div_mul;
    logic              div_step;
    logic              term_lo;
    logic              term_hi;
    logic              term_add;
    logic              fin_mul;
    logic              fin_add;
    logic [LIMB_W-1:0] limb;
    logic              k_lt_i;
    logic              k_eq_i;
    logic              out_load;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] flags;
    logic       stable;
  } sts_t;

endpackage

@@ rtl/column_wave_activity_integrator_top.sv @@
// ----------------------------------------------------------------------------
// column_wave_activity_integrator_top
// Local wave activity for one column of latitude rows.
// ----------------------------------------------------------------------------
// Rows enter north to south on the in_ channel (valid/stall) and are stored.
// The column closes on last_row or after rows_in_use rows; the block then
// stalls its input and sends one result per stored row, in row order, on the
// out_ channel, last_result set on the final one, and reopens for loading.
// Each result runs a loop over all n rows. A stable row is read and its
// scaled excess formed, then divided by 15625 (four base-2^18 digits, a
// reciprocal multiply and a remainder step each) and weighted by a 27x33
// product. An unstable row is only read. Row setup comes before the loop;
// scaling and the load of the result register follow it. A pole or
// missing-PV row skips the loop.
// Loading takes one row per cycle. Results sit in an output register; while
// the receiver stalls, the next result is computed and then waits for it.
// rst_n (synchronous) empties the column, clears the output valid and sets
// rows_in_use to 64 and stable_density_min to 66. Configuration writes on
// cfg_ are always accepted and are meant for an idle block.
// ----------------------------------------------------------------------------
module column_wave_activity_integrator_top #(
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [cwai_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cwai_pkg::DATA_W-1:0]  in_vorticity,
  input  logic [cwai_pkg::DATA_W-1:0]         in_density,
  input  logic signed [cwai_pkg::DATA_W-1:0]  in_pv_background,
  input  logic                                in_pv_missing,
  input  logic                                in_at_pole,
  input  logic [cwai_pkg::DATA_W-1:0]         in_weight_north_half,
  input  logic [cwai_pkg::DATA_W-1:0]         in_weight_south_half,
  input  logic [cwai_pkg::DATA_W-1:0]         in_row_scale,
  input  logic                                in_last_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cwai_pkg::DATA_W-1:0]  out_activity,
  output logic                                out_no_value,
  output logic                                out_last_result
);
  import cwai_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  logic [RIU_W-1:0]  riu_r;
  logic [DATA_W-1:0] sdm_r;
  logic [AW-1:0]     wr_addr, rd_i_addr, rd_k_addr;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      riu_r <= RIU_RESET;
      sdm_r <= SDM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS_IN_USE: riu_r <= cfg_data[RIU_W-1:0];
        CFG_STABLE_MIN:  sdm_r <= cfg_data;
        default:         riu_r <= riu_r;
      endcase
    end
  end

  cwai_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .rows_in_use (riu_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_last_row (in_last_row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .wr_addr     (wr_addr),
    .rd_i_addr   (rd_i_addr),
    .rd_k_addr   (rd_k_addr),
    .cmd         (cmd),
    .sts         (sts)
  );

  cwai_dp #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk                  (clk),
    .stable_density_min   (sdm_r),
    .in_vorticity         (in_vorticity),
    .in_density           (in_density),
    .in_pv_background     (in_pv_background),
    .in_pv_missing        (in_pv_missing),
    .in_at_pole           (in_at_pole),
    .in_weight_north_half (in_weight_north_half),
    .in_weight_south_half (in_weight_south_half),
    .in_row_scale         (in_row_scale),
    .wr_addr              (wr_addr),
    .rd_i_addr            (rd_i_addr),
    .rd_k_addr            (rd_k_addr),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_activity         (out_activity),
    .out_no_value         (out_no_value),
    .out_last_result      (out_last_result)
  );

endmodule

@@ rtl/cwai_ctrl.sv @@
// ----------------------------------------------------------------------------
// cwai_ctrl
// Sequencer: row loading, pair loop, divider steps, finish and result hand-off.
// ----------------------------------------------------------------------------
module cwai_ctrl #(
  parameter int MAX_ROWS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [cwai_pkg::RIU_W-1:0]           rows_in_use,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_last_row,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(MAX_ROWS)-1:0]          wr_addr,
  output logic [$clog2(MAX_ROWS)-1:0]          rd_i_addr,
  output logic [$clog2(MAX_ROWS)-1:0]          rd_k_addr,
  output cwai_pkg::cmd_t                       cmd,
  input  cwai_pkg::sts_t                       sts
);
  import cwai_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int LW = (CW > RIU_W) ? CW : RIU_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_ROWS);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     loaded_r, loaded_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LIMB_W-1:0] limb_r, limb_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LW-1:0]     riu_l, limit;
  logic [LW-1:0]     count_l;
  logic              k_last;

  assign riu_l   = LW'(rows_in_use);
  assign limit   = (riu_l == '0) ? LW'(1) : ((riu_l > MAX_L) ? MAX_L : riu_l);
  assign count_l = LW'(loaded_r) + LW'(1);
  assign k_last  = (k_r + CW'(1)) == n_r;

  assign wr_addr   = loaded_r[AW-1:0];
  assign rd_i_addr = i_r[AW-1:0];
  assign rd_k_addr = k_r[AW-1:0];
  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      loaded_r    <= '0;
      n_r         <= '0;
      i_r         <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      limb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      limb_r      <= limb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    limb_nxt      = limb_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.limb      = limb_r;
    cmd.k_lt_i    = k_r < i_r;
    cmd.k_eq_i    = k_r == i_r;
    cmd.out_last  = (i_r + CW'(1)) == n_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (in_last_row || count_l >= limit) begin
            n_nxt      = loaded_r + CW'(1);
            loaded_nxt = '0;
            i_nxt      = '0;
            state_nxt  = ST_ROW_RD;
          end else begin
            loaded_nxt = loaded_r + CW'(1);
          end
        end
      end
      ST_ROW_RD: state_nxt = ST_ROW_CHK;
      ST_ROW_CHK: begin
        cmd.acc_clr = 1'b1;
        if (sts.flags != 2'b00) begin
          state_nxt = ST_OUT;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_PAIR_RD;
        end
      end
      ST_PAIR_RD: state_nxt = ST_PAIR_MUL;
      ST_PAIR_MUL: begin
        if (sts.stable) begin
          cmd.mul_ps = 1'b1;
          state_nxt  = ST_PAIR_SUB;
        end else if (k_last) begin
          limb_nxt  = '0;
          state_nxt = ST_FIN_MUL;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_PAIR_RD;
        end
      end
      ST_PAIR_SUB: begin
        cmd.form_x = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIV_MUL;
      end
      ST_DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_TERM_LO;
        end else begin
          state_nxt = ST_DIV_MUL;
        end
      end
      ST_TERM_LO: begin
        cmd.term_lo = 1'b1;
        state_nxt   = ST_TERM_HI;
      end
      ST_TERM_HI: begin
        cmd.term_hi = 1'b1;
        state_nxt   = ST_TERM_ADD;
      end
      ST_TERM_ADD: begin
        cmd.term_add = 1'b1;
        if (k_last) begin
          limb_nxt  = '0;
          state_nxt = ST_FIN_MUL;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_PAIR_RD;
        end
      end
      ST_FIN_MUL: begin
        cmd.fin_mul = 1'b1;
        state_nxt   = ST_FIN_ADD;
      end
      ST_FIN_ADD: begin
        cmd.fin_add = 1'b1;
        if (limb_r == LAST_LIMB) begin
          state_nxt = ST_OUT;
        end else begin
          limb_nxt  = limb_r + LIMB_W'(1);
          state_nxt = ST_FIN_MUL;
        end
      end
      ST_OUT: begin
        // result register free or being taken this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          if (cmd.out_last) begin
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_ROW_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

@@ rtl/cwai_dp.sv @@
// ----------------------------------------------------------------------------
// cwai_dp
// Row stores, excess computation, digit divider, weighted accumulation and
// scaling with saturation.
// ----------------------------------------------------------------------------
module cwai_dp #(
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic [cwai_pkg::DATA_W-1:0]         stable_density_min,
  input  logic signed [cwai_pkg::DATA_W-1:0]  in_vorticity,
  input  logic [cwai_pkg::DATA_W-1:0]         in_density,
  input  logic signed [cwai_pkg::DATA_W-1:0]  in_pv_background,
  input  logic                                in_pv_missing,
  input  logic                                in_at_pole,
  input  logic [cwai_pkg::DATA_W-1:0]         in_weight_north_half,
  input  logic [cwai_pkg::DATA_W-1:0]         in_weight_south_half,
  input  logic [cwai_pkg::DATA_W-1:0]         in_row_scale,
  input  logic [$clog2(MAX_ROWS)-1:0]         wr_addr,
  input  logic [$clog2(MAX_ROWS)-1:0]         rd_i_addr,
  input  logic [$clog2(MAX_ROWS)-1:0]         rd_k_addr,
  input  cwai_pkg::cmd_t                      cmd,
  output cwai_pkg::sts_t                      sts,
  output logic signed [cwai_pkg::DATA_W-1:0]  out_activity,
  output logic                                out_no_value,
  output logic                                out_last_result
);
  import cwai_pkg::*;

  localparam int XW = MAG_W + 2;

  logic [DATA_W-1:0] vort_mem  [MAX_ROWS];
  logic [DATA_W-1:0] dens_mem  [MAX_ROWS];
  logic [DATA_W-1:0] cont_mem  [MAX_ROWS];
  logic [DATA_W-1:0] wn_mem    [MAX_ROWS];
  logic [DATA_W-1:0] ws_mem    [MAX_ROWS];
  logic [DATA_W-1:0] scale_mem [MAX_ROWS];
  logic [1:0]        flag_mem  [MAX_ROWS];

  logic [DATA_W-1:0] vort_q, dens_q, cont_q, wn_q, ws_q, scale_q;
  logic [1:0]        flag_q;

  logic signed [DATA_W*2:0] m_r;
  logic                     xneg_r;
  logic [REM_W-1:0]         rem_r;
  logic [DQ_W-1:0]          dq_r;
  logic [PROD_W-1:0]        rp_r;
  logic [PROD_W-1:0]        prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic [FIN_W-1:0]         fin_r;
  logic signed [DATA_W-1:0] act_r;
  logic                     nov_r, last_r;

  logic signed [XW-1:0] x_w;
  logic [XW-1:0]        xmag_w;
  logic [DATA_W-1:0]    n_w;
  logic [DIV_CHUNK-1:0] q_w;
  logic [DATA_W-1:0]    r_w;
  logic [DMAG_W-1:0]    dmag_w;
  logic [WSUM_W-1:0]    wsum_w, wsel_w;
  logic [DATA_W-1:0]    limb_w;
  logic [DATA_W-1:0]    sat_w;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      vort_mem[wr_addr]  <= in_vorticity;
      dens_mem[wr_addr]  <= in_density;
      cont_mem[wr_addr]  <= in_pv_background;
      wn_mem[wr_addr]    <= in_weight_north_half;
      ws_mem[wr_addr]    <= in_weight_south_half;
      scale_mem[wr_addr] <= in_row_scale;
      flag_mem[wr_addr]  <= {in_at_pole, in_pv_missing};
    end
    cont_q  <= cont_mem[rd_i_addr];
    scale_q <= scale_mem[rd_i_addr];
    flag_q  <= flag_mem[rd_i_addr];
    vort_q  <= vort_mem[rd_k_addr];
    dens_q  <= dens_mem[rd_k_addr];
    wn_q    <= wn_mem[rd_k_addr];
    ws_q    <= ws_mem[rd_k_addr];
  end

  assign sts.flags  = flag_q;
  assign sts.stable = dens_q >= stable_density_min;

  // scaled excess: 15625*v - 4*p*s, floor of its quotient is the excess
  assign x_w = ($signed({{(XW-DATA_W){vort_q[DATA_W-1]}}, vort_q}) * XW'(DENOM))
             - ($signed({{(XW-DATA_W*2-1){m_r[DATA_W*2]}}, m_r}) <<< 2);
  assign xmag_w = x_w[XW-1] ? XW'(-x_w) : XW'(x_w);

  // one base-2^18 digit per step, quotient digit by reciprocal multiply
  assign n_w = {rem_r, dq_r[DQ_W-1 -: DIV_CHUNK]};
  assign q_w = rp_r[RECIP_SHIFT+DIV_CHUNK-1:RECIP_SHIFT];
  assign r_w = n_w - (DATA_W'(q_w) * DATA_W'(DENOM));

  // magnitude of the floor quotient
  assign dmag_w = dq_r[DMAG_W-1:0] + DMAG_W'(xneg_r && (rem_r != '0));

  assign wsum_w = WSUM_W'(wn_q) + WSUM_W'(ws_q);
  always_comb begin
    if (cmd.k_eq_i) begin
      wsel_w = xneg_r ? WSUM_W'(wn_q) : WSUM_W'(ws_q);
    end else if (cmd.k_lt_i) begin
      wsel_w = xneg_r ? wsum_w : '0;
    end else begin
      wsel_w = xneg_r ? '0 : wsum_w;
    end
  end

  always_comb begin
    unique case (cmd.limb)
      2'd0:    limb_w = acc_r[DATA_W-1:0];
      2'd1:    limb_w = acc_r[2*DATA_W-1:DATA_W];
      default: limb_w = acc_r[3*DATA_W-1:2*DATA_W];
    endcase
  end

  assign sat_w = (fin_r[FIN_W-1:FIN_SHIFT+DATA_W-1] != '0) ? 32'h7FFF_FFFF
               : DATA_W'(fin_r[FIN_SHIFT+DATA_W-2:FIN_SHIFT]);

  always_ff @(posedge clk) begin
    if (cmd.mul_ps) begin
      m_r <= (DATA_W*2+1)'($signed(cont_q) * $signed({1'b0, dens_q}));
    end
    if (cmd.form_x) begin
      xneg_r <= x_w[XW-1];
      dq_r   <= DQ_W'(xmag_w);
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= r_w[REM_W-1:0];
      dq_r  <= {dq_r[DQ_W-DIV_CHUNK-1:0], q_w};
    end
    if (cmd.div_mul) begin
      rp_r <= PROD_W'(n_w * RECIP);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
      fin_r <= '0;
    end else begin
      if (cmd.term_hi) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end else if (cmd.term_add) begin
        acc_r <= acc_r + (ACC_W'(prod_r) << DHALF_W);
      end
      if (cmd.fin_add) begin
        fin_r <= fin_r + (FIN_W'(prod_r) << (DATA_W * 32'(cmd.limb)));
      end
    end
    if (cmd.term_lo) begin
      prod_r <= PROD_W'(dmag_w[DHALF_W-1:0] * wsel_w);
    end else if (cmd.term_hi) begin
      prod_r <= PROD_W'(dmag_w[DMAG_W-1:DHALF_W] * wsel_w);
    end else if (cmd.fin_mul) begin
      prod_r <= PROD_W'(limb_w * scale_q);
    end
    if (cmd.out_load) begin
      act_r  <= (flag_q != 2'b00) ? '0 : $signed(sat_w);
      nov_r  <= flag_q[0];
      last_r <= cmd.out_last;
    end
  end

  assign out_activity    = act_r;
  assign out_no_value    = nov_r;
  assign out_last_result = last_r;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Column wave activity integrator: columns of latitude rows go in, one
// activity value per row comes out. A scoreboard predicts every result at
// the moment its column closes and checks results in order, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import cwai_pkg::*;

  typedef struct {
    logic signed [31:0] vort;
    logic [31:0]        dens;
    logic signed [31:0] pv;
    logic               miss;
    logic               pole;
    logic [31:0]        wn;
    logic [31:0]        ws;
    logic [31:0]        scale;
    logic               last;
  } row_t;

  typedef struct {
    logic signed [31:0] act;
    logic               nv;
    logic               last;
  } activity_t;

  localparam logic signed [127:0] CONTOUR_DIV = 128'sd15625;

  class activity_scoreboard;
    row_t        column_q[$];
    activity_t   expected_q[$];
    int unsigned rows_limit = 64;
    logic [31:0] stable_min = 32'd66;
    int          errors = 0;

    function logic signed [31:0] activity_of(int i);
      logic signed [127:0] acc, num, q, d, vv, wn, ws;
      logic [127:0]        mag_acc;
      logic [191:0]        mag, qq;
      logic                neg;
      acc = 0;
      for (int k = 0; k < column_q.size(); k++) begin
        if (column_q[k].dens < stable_min) continue;
        num = column_q[i].pv;
        num = num * $signed({96'd0, column_q[k].dens});
        num = num * 128'sd4;
        q = num / CONTOUR_DIV;
        if (num > 0 && (num % CONTOUR_DIV) != 0) q = q + 1;
        vv = column_q[k].vort;
        d = vv - q;
        wn = $signed({96'd0, column_q[k].wn});
        ws = $signed({96'd0, column_q[k].ws});
        if (k < i) begin
          if (d < 0) acc = acc - d * (wn + ws);
        end else if (k > i) begin
          if (d >= 0) acc = acc + d * (wn + ws);
        end else if (d < 0) begin
          acc = acc - d * wn;
        end else begin
          acc = acc + d * ws;
        end
      end
      neg = acc < 0;
      mag_acc = neg ? -acc : acc;
      mag = {64'd0, mag_acc} * {160'd0, column_q[i].scale};
      qq = mag >> 54;
      if (!neg) return (qq > 192'h7FFFFFFF) ? 32'h7FFFFFFF : qq[31:0];
      if (qq > 192'h80000000) return 32'h80000000;
      return -qq[31:0];
    endfunction

    function void note_row(row_t r);
      int unsigned lim;
      activity_t e;
      lim = rows_limit < 1 ? 1 : (rows_limit > 64 ? 64 : rows_limit);
      column_q.push_back(r);
      if (!r.last && column_q.size() < lim) return;
      for (int i = 0; i < column_q.size(); i++) begin
        e.act = (column_q[i].miss || column_q[i].pole) ? 32'sd0 : activity_of(i);
        e.nv = column_q[i].miss;
        e.last = (i == column_q.size() - 1);
        expected_q.push_back(e);
      end
      column_q.delete();
    endfunction

    function void check_result(logic signed [31:0] act, logic nv, logic last);
      activity_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result act=%0d nv=%0b last=%0b", act, nv, last);
        return;
      end
      e = expected_q.pop_front();
      if (act !== e.act || nv !== e.nv || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp act=%0d nv=%0b last=%0b, got act=%0d nv=%0b last=%0b",
                   e.act, e.nv, e.last, act, nv, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [31:0] in_vorticity, in_pv_background;
  logic [31:0] in_density, in_weight_north_half, in_weight_south_half, in_row_scale;
  logic in_pv_missing, in_at_pole, in_last_row;
  logic out_valid, out_stall, out_no_value, out_last_result;
  logic signed [31:0] out_activity;

  activity_scoreboard sb = new();
  int unsigned cyc = 0;
  int unsigned rows_sent = 0;
  logic calm;

  column_wave_activity_integrator_top dut (.*);

  always #1 clk = ~clk;

  assign calm = (cyc >= 3000 && cyc < 15000);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_activity, out_no_value, out_last_result);
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(negedge clk);
      if (cfg_ready) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS_IN_USE) sb.rows_limit = value[6:0];
    else sb.stable_min = value;
  endtask

  task automatic send_row(input row_t r);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vorticity <= r.vort;
    in_density <= r.dens;
    in_pv_background <= r.pv;
    in_pv_missing <= r.miss;
    in_at_pole <= r.pole;
    in_weight_north_half <= r.wn;
    in_weight_south_half <= r.ws;
    in_row_scale <= r.scale;
    in_last_row <= r.last;
    forever begin
      @(negedge clk);
      if (!in_stall) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    sb.note_row(r);
    rows_sent++;
  endtask

  // mode 0: plausible magnitudes, 1: full range, 2: unstable density
  function automatic row_t make_row(int mode, logic last);
    row_t r;
    r.vort = $urandom();
    r.miss = ($urandom_range(0, 99) < 8);
    r.pole = ($urandom_range(0, 99) < 8);
    r.last = last;
    if (mode == 1) begin
      r.dens = $urandom();
      r.pv = $urandom();
      r.wn = ($urandom_range(0, 9) == 0) ? 32'h80000000 : $urandom_range(0, 32'h80000000);
      r.ws = ($urandom_range(0, 9) == 0) ? 32'h80000000 : $urandom_range(0, 32'h80000000);
      r.scale = $urandom();
    end else begin
      r.dens = (mode == 2) ? $urandom_range(0, 65) : $urandom_range(0, 32'h7FFFFF);
      r.pv = $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
      r.wn = $urandom_range(0, 32'h3FFFFFF);
      r.ws = $urandom_range(0, 32'h3FFFFFF);
      r.scale = $urandom_range(0, 32'hFFFFF);
    end
    return r;
  endfunction

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    row_t r;
    int unsigned lim, len;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROWS_IN_USE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_vorticity <= '0;
    in_density <= '0;
    in_pv_background <= '0;
    in_pv_missing <= 1'b0;
    in_at_pole <= 1'b0;
    in_weight_north_half <= '0;
    in_weight_south_half <= '0;
    in_row_scale <= '0;
    in_last_row <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, column closed by count
    write_reg(CFG_ROWS_IN_USE, 32'd3);
    r = '{32'sh7FFFFFFF, 32'hFFFFFFFF, 32'sh7FFFFFFF, 1'b0, 1'b0,
          32'h80000000, 32'h80000000, 32'hFFFFFFFF, 1'b0};
    send_row(r);
    r = '{32'sh80000000, 32'hFFFFFFFF, 32'sh80000000, 1'b0, 1'b0,
          32'h80000000, 32'h0, 32'hFFFFFFFF, 1'b0};
    send_row(r);
    r = '{32'sh0, 32'h0, 32'sh0, 1'b0, 1'b0, 32'h0, 32'h80000000, 32'h0, 1'b0};
    send_row(r);
    // single-row column closed early by last row
    r = make_row(0, 1'b1);
    r.miss = 0;
    r.pole = 0;
    send_row(r);
    // missing contour, pole, and both together
    r = make_row(0, 1'b0); r.miss = 1; r.pole = 0; send_row(r);
    r = make_row(0, 1'b0); r.miss = 0; r.pole = 1; send_row(r);
    r = make_row(0, 1'b1); r.miss = 1; r.pole = 1; send_row(r);
    drain();

    // zero stability threshold with zero density rows
    write_reg(CFG_STABLE_MIN, 32'd0);
    for (int j = 0; j < 3; j++) begin
      r = make_row(0, 1'b0);
      r.miss = 0; r.pole = 0;
      if (j != 1) r.dens = 0;
      send_row(r);
    end
    drain();
    write_reg(CFG_STABLE_MIN, 32'hFFFFFFFF);
    for (int j = 0; j < 3; j++) begin
      r = make_row(1, 1'b0);
      if (j == 0) r.dens = 32'hFFFFFFFF;
      send_row(r);
    end
    drain();

    // full column of 64, mostly unstable rows to keep it short
    write_reg(CFG_ROWS_IN_USE, 32'd64);
    write_reg(CFG_STABLE_MIN, 32'd66);
    for (int j = 0; j < 64; j++) send_row(make_row(($urandom_range(0, 15) == 0) ? 0 : 2, 1'b0));
    drain();

    while (rows_sent < 230) begin
      case ($urandom_range(0, 3))
        0: lim = 3;
        1: lim = 64;
        default: lim = $urandom_range(3, 8);
      endcase
      write_reg(CFG_ROWS_IN_USE, lim);
      case ($urandom_range(0, 4))
        0: write_reg(CFG_STABLE_MIN, 32'd0);
        1: write_reg(CFG_STABLE_MIN, 32'd66);
        2: write_reg(CFG_STABLE_MIN, 32'hFFFFFFFF);
        default: write_reg(CFG_STABLE_MIN, $urandom_range(0, 32'h3FFFFF));
      endcase
      repeat ($urandom_range(2, 6)) begin
        len = $urandom_range(1, (lim > 8) ? 8 : lim);
        for (int j = 0; j < len; j++)
          send_row(make_row(($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0,
                            (j == len - 1) ? ((len < lim) ? 1'b1 : $urandom_range(0, 1))
                                           : 1'b0));
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
